### rtl/fpis_pkg.sv
// Package with the types, constants and helper functions of the frame pair interval statistics block.
`default_nettype none
package fpis_pkg;

    localparam int MAX_SAMPLES = 16384;
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = ADDR_W + 1;
    localparam int SMP_W = 23;
    localparam int SUM_W = SMP_W + ADDR_W;
    localparam int TIME_W = 48;
    localparam int WARM_W = 27;
    localparam int MINS_W = 15;
    localparam int BIT_W = $clog2(SMP_W);
    localparam int X_W = CNT_W + 11;
    localparam int P_W = 2 * X_W + 1;
    localparam int RECIP_SH = X_W + 10;
    localparam logic [63:0] RECIP_M = ((64'd1 << RECIP_SH) + 64'd999) / 64'd1000;

    localparam logic [TIME_W-1:0] SEVERE_US = 48'd5000000;
    localparam logic [SMP_W-1:0] THR_40 = 23'd40000;
    localparam logic [SMP_W-1:0] THR_50 = 23'd50000;
    localparam logic [SMP_W-1:0] THR_75 = 23'd75000;
    localparam logic [SMP_W-1:0] THR_100 = 23'd100000;

    localparam logic [WARM_W-1:0] WARMUP_RST = 27'd2000000;
    localparam logic [MINS_W-1:0] MINS_RST = 15'd32;

    localparam logic [1:0] CMD_PRESENT = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [0:0] CFG_WARMUP = 1'b0;
    localparam logic [0:0] CFG_MIN_SAMPLES = 1'b1;

    localparam logic [1:0] STS_VALID = 2'd0;
    localparam logic [1:0] STS_TOO_FEW = 2'd1;
    localparam logic [1:0] STS_DIRTY = 2'd2;

    localparam logic [3:0] K_N = 4'd0;
    localparam logic [3:0] K_MEAN = 4'd1;
    localparam logic [3:0] K_P50 = 4'd2;
    localparam logic [3:0] K_P95 = 4'd3;
    localparam logic [3:0] K_P99 = 4'd4;
    localparam logic [3:0] K_P999 = 4'd5;
    localparam logic [3:0] K_MAX = 4'd6;
    localparam logic [3:0] K_OVER2X = 4'd7;
    localparam logic [3:0] K_O40 = 4'd8;
    localparam logic [3:0] K_O50 = 4'd9;
    localparam logic [3:0] K_O75 = 4'd10;
    localparam logic [3:0] K_O100 = 4'd11;
    localparam logic [3:0] K_SEVERE = 4'd12;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] time_us;
        logic              in_play;
    } t_in;

    typedef struct packed {
        logic [3:0]  stat_kind;
        logic [31:0] stat_value;
        logic [1:0]  seg_status;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_IDXA,
        ST_IDXB,
        ST_PCT,
        ST_OVER,
        ST_DIV,
        ST_EMIT
    } t_state;

    function automatic logic [9:0] pct_milli(input logic [1:0] sel);
        logic [9:0] m;
        case (sel)
            2'd0: m = 10'd500;
            2'd1: m = 10'd950;
            2'd2: m = 10'd990;
            default: m = 10'd999;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

### rtl/fpis_div.sv
// Restoring divider that produces the truncated mean one quotient bit per cycle.
`default_nettype none
module fpis_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [fpis_pkg::SUM_W-1:0]   i_dividend,
    input  wire logic [fpis_pkg::CNT_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [fpis_pkg::SUM_W-1:0]        o_quotient
);

    localparam int STEP_W = $clog2(fpis_pkg::SUM_W + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [fpis_pkg::CNT_W-1:0]    r_rem;
    logic [fpis_pkg::SUM_W-1:0]    r_quo;
    logic [fpis_pkg::CNT_W-1:0]    r_dvs;
    logic [fpis_pkg::CNT_W:0]      trial;
    logic                          fits;

    assign trial = {r_rem, r_quo[fpis_pkg::SUM_W-1]};
    assign fits = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_W'(fpis_pkg::SUM_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? fpis_pkg::CNT_W'(trial - {1'b0, r_dvs})
                          : trial[fpis_pkg::CNT_W-1:0];
            r_quo <= {r_quo[fpis_pkg::SUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

### rtl/frame_pair_interval_stats_top.sv
// Top level of the frame pair interval statistics block: pairing, sample store and close engine.
`default_nettype none
// Present and start requests are taken whenever the block is idle. A close request with a
// valid segment of n samples walks the sample memory once for sum, maximum and threshold
// counts, then 92 more times (23 bisection steps for each of four percentiles, one read port,
// one entry a cycle), and once for the count over twice the median, before the 13 results
// appear, one per accepted output request. A close with a dirty or short segment emits at
// once. No request is taken until the last result of a close has been accepted.
module frame_pair_interval_stats_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire fpis_pkg::t_in     i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output fpis_pkg::t_out         o_out_data,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_idx,
    input  wire logic [26:0]       i_cfg_data
);

    localparam int AW = fpis_pkg::ADDR_W;
    localparam int CW = fpis_pkg::CNT_W;
    localparam int SW = fpis_pkg::SMP_W;
    localparam int TW = fpis_pkg::TIME_W;

    fpis_pkg::t_state r_state, n_state;

    logic [fpis_pkg::WARM_W-1:0] r_warmup;
    logic [fpis_pkg::MINS_W-1:0] r_min;

    logic [SW-1:0]  r_mem [fpis_pkg::MAX_SAMPLES];
    logic [SW-1:0]  r_rdata;
    logic           r_rvld;
    logic [CW-1:0]  r_iss;

    logic [CW-1:0]  r_count;
    logic           r_parity;
    logic [TW-1:0]  r_lpt;
    logic           r_lpv;
    logic [TW-1:0]  r_seg_start;
    logic [31:0]    r_severe;
    logic           r_dirty;
    logic           r_active;

    logic [1:0]     r_status;
    logic [fpis_pkg::SUM_W-1:0] r_sum;
    logic [SW-1:0]  r_max;
    logic [CW-1:0]  r_o40, r_o50, r_o75, r_o100, r_over;
    logic [CW-1:0]  r_lt;
    logic [SW-1:0]  r_ans;
    logic [fpis_pkg::BIT_W-1:0] r_bit;
    logic [1:0]     r_sel;
    logic [SW-1:0]  r_p [4];
    logic [fpis_pkg::X_W-1:0] r_x;
    logic [CW-1:0]  r_k;
    logic [3:0]     r_kind;

    logic           in_acc;
    logic           scanning, scan_issue, scan_end;
    logic [TW-1:0]  since, dlt;
    logic           mem_we;
    logic [SW-1:0]  trial, ans_n;
    logic [fpis_pkg::P_W-1:0] prod;
    logic [CW-1:0]  q, q_cl;
    logic [fpis_pkg::MINS_W-1:0] need;
    logic           div_start, div_done;
    logic [fpis_pkg::SUM_W-1:0] div_quo;
    logic [31:0]    val;

    assign o_in_ready = (r_state == fpis_pkg::ST_IDLE);
    assign in_acc = i_in_valid && o_in_ready;

    assign scanning = (r_state == fpis_pkg::ST_SUM) || (r_state == fpis_pkg::ST_PCT)
                   || (r_state == fpis_pkg::ST_OVER);
    assign scan_issue = scanning && (r_iss < r_count);
    assign scan_end = scanning && (r_iss == r_count) && !r_rvld;

    assign since = i_in_data.time_us - r_seg_start;
    assign dlt = i_in_data.time_us - r_lpt;
    assign need = (r_min == '0) ? fpis_pkg::MINS_W'(1) : r_min;

    assign mem_we = in_acc && (i_in_data.cmd == fpis_pkg::CMD_PRESENT) && r_active
                 && i_in_data.in_play && !(since < TW'(r_warmup)) && r_parity && r_lpv
                 && (dlt < fpis_pkg::SEVERE_US) && (dlt != '0)
                 && (r_count < CW'(fpis_pkg::MAX_SAMPLES));

    assign trial = r_ans | (SW'(1) << r_bit);
    assign ans_n = (r_lt < r_k) ? trial : r_ans;

    assign prod = fpis_pkg::P_W'(r_x) * fpis_pkg::P_W'(fpis_pkg::RECIP_M);
    assign q = prod[fpis_pkg::RECIP_SH +: CW];
    assign q_cl = (q >= r_count) ? r_count - 1'b1 : q;

    assign div_start = (r_state == fpis_pkg::ST_SUM) && scan_end;

    fpis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= dlt[SW-1:0];
        end
        r_rdata <= r_mem[r_iss[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpis_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpis_pkg::ST_IDLE: begin
                if (in_acc && (i_in_data.cmd == fpis_pkg::CMD_CLOSE) && r_active) begin
                    if (r_dirty || (32'(r_count) < 32'(need))) begin
                        n_state = fpis_pkg::ST_EMIT;
                    end else begin
                        n_state = fpis_pkg::ST_SUM;
                    end
                end
            end
            fpis_pkg::ST_SUM: begin
                if (scan_end) begin
                    n_state = fpis_pkg::ST_IDXA;
                end
            end
            fpis_pkg::ST_IDXA: n_state = fpis_pkg::ST_IDXB;
            fpis_pkg::ST_IDXB: n_state = fpis_pkg::ST_PCT;
            fpis_pkg::ST_PCT: begin
                if (scan_end && (r_bit == '0)) begin
                    n_state = (r_sel == 2'd3) ? fpis_pkg::ST_OVER : fpis_pkg::ST_IDXA;
                end
            end
            fpis_pkg::ST_OVER: begin
                if (scan_end) begin
                    n_state = fpis_pkg::ST_DIV;
                end
            end
            fpis_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = fpis_pkg::ST_EMIT;
                end
            end
            fpis_pkg::ST_EMIT: begin
                if (i_out_ready && (r_kind == fpis_pkg::K_SEVERE)) begin
                    n_state = fpis_pkg::ST_IDLE;
                end
            end
            default: n_state = fpis_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup <= fpis_pkg::WARMUP_RST;
            r_min <= fpis_pkg::MINS_RST;
            r_count <= '0;
            r_parity <= 1'b0;
            r_lpt <= '0;
            r_lpv <= 1'b0;
            r_seg_start <= '0;
            r_severe <= '0;
            r_dirty <= 1'b0;
            r_active <= 1'b0;
            r_rvld <= 1'b0;
            r_iss <= '0;
            r_kind <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == fpis_pkg::CFG_WARMUP) begin
                    r_warmup <= i_cfg_data;
                end else begin
                    r_min <= i_cfg_data[fpis_pkg::MINS_W-1:0];
                end
            end
            r_rvld <= scan_issue;
            if (scan_issue) begin
                r_iss <= r_iss + 1'b1;
            end
            if (in_acc) begin
                case (i_in_data.cmd)
                    fpis_pkg::CMD_PRESENT: begin
                        if (r_active) begin
                            if (!i_in_data.in_play) begin
                                r_dirty <= 1'b1;
                            end else if (since < TW'(r_warmup)) begin
                                r_parity <= 1'b0;
                                r_lpv <= 1'b0;
                            end else begin
                                r_parity <= ~r_parity;
                                if (r_parity) begin
                                    if (r_lpv && (dlt >= fpis_pkg::SEVERE_US)
                                        && (r_severe != '1)) begin
                                        r_severe <= r_severe + 1'b1;
                                    end
                                    if (mem_we) begin
                                        r_count <= r_count + 1'b1;
                                    end
                                    r_lpt <= i_in_data.time_us;
                                    r_lpv <= 1'b1;
                                end
                            end
                        end
                    end
                    fpis_pkg::CMD_START: begin
                        r_seg_start <= i_in_data.time_us;
                        r_count <= '0;
                        r_parity <= 1'b0;
                        r_lpt <= '0;
                        r_lpv <= 1'b0;
                        r_severe <= '0;
                        r_dirty <= 1'b0;
                        r_active <= 1'b1;
                    end
                    fpis_pkg::CMD_CLOSE: begin
                        r_active <= 1'b0;
                        r_iss <= '0;
                        r_kind <= fpis_pkg::K_N;
                    end
                    default: ;
                endcase
            end
            if ((r_state == fpis_pkg::ST_IDXB)
                || ((r_state == fpis_pkg::ST_PCT) && scan_end && (r_bit != '0))
                || ((r_state == fpis_pkg::ST_PCT) && scan_end && (r_sel == 2'd3))) begin
                r_iss <= '0;
            end
            if (r_state == fpis_pkg::ST_DIV) begin
                r_kind <= fpis_pkg::K_N;
            end
            if ((r_state == fpis_pkg::ST_EMIT) && i_out_ready) begin
                r_kind <= r_kind + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.cmd == fpis_pkg::CMD_CLOSE)) begin
            if (r_dirty) begin
                r_status <= fpis_pkg::STS_DIRTY;
            end else if (32'(r_count) < 32'(need)) begin
                r_status <= fpis_pkg::STS_TOO_FEW;
            end else begin
                r_status <= fpis_pkg::STS_VALID;
            end
            r_sum <= '0;
            r_max <= '0;
            r_o40 <= '0;
            r_o50 <= '0;
            r_o75 <= '0;
            r_o100 <= '0;
            r_over <= '0;
            r_sel <= '0;
        end
        if (r_rvld) begin
            case (r_state)
                fpis_pkg::ST_SUM: begin
                    r_sum <= r_sum + fpis_pkg::SUM_W'(r_rdata);
                    if (r_rdata > r_max) r_max <= r_rdata;
                    if (r_rdata >= fpis_pkg::THR_40) r_o40 <= r_o40 + 1'b1;
                    if (r_rdata >= fpis_pkg::THR_50) r_o50 <= r_o50 + 1'b1;
                    if (r_rdata >= fpis_pkg::THR_75) r_o75 <= r_o75 + 1'b1;
                    if (r_rdata >= fpis_pkg::THR_100) r_o100 <= r_o100 + 1'b1;
                end
                fpis_pkg::ST_PCT: begin
                    if (r_rdata < trial) r_lt <= r_lt + 1'b1;
                end
                fpis_pkg::ST_OVER: begin
                    if ({1'b0, r_rdata} > {r_p[0], 1'b0}) r_over <= r_over + 1'b1;
                end
                default: ;
            endcase
        end
        if (r_state == fpis_pkg::ST_IDXA) begin
            r_x <= fpis_pkg::X_W'(fpis_pkg::pct_milli(r_sel)) * fpis_pkg::X_W'(r_count - 1'b1)
                 + fpis_pkg::X_W'(500);
        end
        if (r_state == fpis_pkg::ST_IDXB) begin
            r_k <= q_cl + 1'b1;
            r_ans <= '0;
            r_bit <= fpis_pkg::BIT_W'(SW - 1);
            r_lt <= '0;
        end
        if ((r_state == fpis_pkg::ST_PCT) && scan_end) begin
            r_lt <= '0;
            if (r_bit == '0) begin
                r_p[r_sel] <= ans_n;
                r_sel <= r_sel + 1'b1;
            end else begin
                r_ans <= ans_n;
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    always_comb begin
        case (r_kind)
            fpis_pkg::K_N:      val = 32'(r_count);
            fpis_pkg::K_MEAN:   val = 32'(div_quo);
            fpis_pkg::K_P50:    val = 32'(r_p[0]);
            fpis_pkg::K_P95:    val = 32'(r_p[1]);
            fpis_pkg::K_P99:    val = 32'(r_p[2]);
            fpis_pkg::K_P999:   val = 32'(r_p[3]);
            fpis_pkg::K_MAX:    val = 32'(r_max);
            fpis_pkg::K_OVER2X: val = 32'(r_over);
            fpis_pkg::K_O40:    val = 32'(r_o40);
            fpis_pkg::K_O50:    val = 32'(r_o50);
            fpis_pkg::K_O75:    val = 32'(r_o75);
            fpis_pkg::K_O100:   val = 32'(r_o100);
            default:            val = r_severe;
        endcase
        if ((r_status != fpis_pkg::STS_VALID) && (r_kind != fpis_pkg::K_SEVERE)) begin
            val = '0;
        end
    end

    assign o_out_valid = (r_state == fpis_pkg::ST_EMIT);
    assign o_out_data.stat_kind = r_kind;
    assign o_out_data.stat_value = val;
    assign o_out_data.seg_status = r_status;
    assign o_out_data.last = (r_kind == fpis_pkg::K_SEVERE);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while results are pending");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(fpis_pkg::MAX_SAMPLES))
        else $error("sample count beyond store depth");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last) |=> (!o_out_valid && o_in_ready))
        else $error("results continue after the last one");
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !scanning)
        else $error("store written during a scan");
`endif

endmodule
`default_nettype wire
